/* src/italp_pkg.sv */
// Shared types and constants for the active interrupt line parser.
package italp_pkg;

   localparam int unsigned IRQ_W = 12;
   localparam int unsigned COUNT_W = 13;
   localparam int unsigned BYTES_W = 17;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned USER_W = 2;
   localparam int unsigned MAX_IRQ = 4095;
   localparam int unsigned BUFFER_BYTES = 128 * 1024;

   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(4096);
   localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = COUNT_W'(512);
   localparam logic [BYTES_W-1:0] BYTE_LIMIT = BYTES_W'(BUFFER_BYTES - 1);

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;

   typedef enum logic [4:0] {
      PH_LEAD = 5'b00001,
      PH_NUM  = 5'b00010,
      PH_GAP  = 5'b00100,
      PH_CNT  = 5'b01000,
      PH_SKIP = 5'b10000
   } phase_type;

   typedef struct packed {
      logic               found;
      logic               done;
      logic [IRQ_W-1:0]   irq;
      logic [COUNT_W-1:0] count;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* src/italp_front.sv */
// Byte parser that classifies table text and queues line and done records.
module italp_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [italp_pkg::COUNT_W-1:0]  csr_wdata,
   input  logic                           accept,
   input  logic [7:0]                     text_byte,
   input  logic                           final_byte,
   output logic                           push,
   output italp_pkg::record_type          push_rec
);

   italp_pkg::phase_type             phase_ff, phase_in;
   logic                             header_ff, header_in;
   logic [italp_pkg::IRQ_W-1:0]      acc_ff, acc_in;
   logic                             nz_ff, nz_in;
   logic [italp_pkg::COUNT_W-1:0]    rep_ff, rep_in;
   logic [italp_pkg::BYTES_W-1:0]    bytes_ff, bytes_in;
   logic                             fin_ff, fin_in;
   logic [italp_pkg::COUNT_W-1:0]    max_count_ff, max_count_in;

   always_comb begin
      logic                          ws;
      logic                          dig;
      logic                          ending;
      logic                          take;
      logic [3:0]                    d;
      logic [15:0]                   v;
      logic [italp_pkg::COUNT_W-1:0] lim;
      logic                          found;
      logic [italp_pkg::IRQ_W-1:0]   irq;
      italp_pkg::phase_type          ph;
      logic                          hdr;
      logic [italp_pkg::IRQ_W-1:0]   acc;
      logic                          nz;
      logic [italp_pkg::COUNT_W-1:0] rep;
      logic [italp_pkg::BYTES_W-1:0] bts;
      logic                          fin;

      ws = (text_byte == italp_pkg::CH_SPACE) || (text_byte == italp_pkg::CH_TAB);
      dig = (text_byte >= italp_pkg::CH_DIGIT_0) && (text_byte <= italp_pkg::CH_DIGIT_9);
      d = dig ? text_byte[3:0] : 4'd0;
      v = 16'({acc_ff, 3'b000}) + 16'({acc_ff, 1'b0}) + {12'd0, d};
      ending = (text_byte == 8'd0) || final_byte;
      take = (text_byte != 8'd0) && !fin_ff && (bytes_ff < italp_pkg::BYTE_LIMIT);
      lim = (max_count_ff > italp_pkg::COUNT_CAP) ? italp_pkg::COUNT_CAP : max_count_ff;

      ph = phase_ff;
      hdr = header_ff;
      acc = acc_ff;
      nz = nz_ff;
      rep = rep_ff;
      bts = bytes_ff;
      fin = fin_ff;
      found = 1'b0;
      irq = '0;

      if (take) begin
         bts = bts + 1'b1;
         if (text_byte == italp_pkg::CH_NEWLINE) begin
            if (nz) begin
               if (rep < lim) begin
                  rep = rep + 1'b1;
                  found = 1'b1;
                  irq = acc;
               end else begin
                  fin = 1'b1;
               end
            end
            ph = italp_pkg::PH_LEAD;
            nz = 1'b0;
            acc = '0;
         end else begin
            unique case (ph)
               italp_pkg::PH_LEAD: begin
                  if (!hdr) begin
                     hdr = 1'b1;
                     ph = italp_pkg::PH_SKIP;
                  end else if (ws) begin
                     ph = italp_pkg::PH_LEAD;
                  end else if (dig) begin
                     acc = {8'd0, d};
                     ph = italp_pkg::PH_NUM;
                  end else begin
                     ph = italp_pkg::PH_SKIP;
                  end
               end
               italp_pkg::PH_NUM: begin
                  if (dig) begin
                     if (v > 16'(italp_pkg::MAX_IRQ)) begin
                        ph = italp_pkg::PH_SKIP;
                     end else begin
                        acc = v[italp_pkg::IRQ_W-1:0];
                     end
                  end else if (text_byte == italp_pkg::CH_COLON) begin
                     nz = 1'b0;
                     ph = italp_pkg::PH_GAP;
                  end else begin
                     ph = italp_pkg::PH_SKIP;
                  end
               end
               italp_pkg::PH_GAP, italp_pkg::PH_CNT: begin
                  if (dig) begin
                     if (d != 4'd0) begin
                        nz = 1'b1;
                     end
                     ph = italp_pkg::PH_CNT;
                  end else if (ws) begin
                     ph = italp_pkg::PH_GAP;
                  end else begin
                     ph = italp_pkg::PH_SKIP;
                  end
               end
               default: begin
                  ph = italp_pkg::PH_SKIP;
               end
            endcase
         end
      end

      // The open line is finished when the scan ends, unless the limit already stopped it.
      if (ending && !fin && nz) begin
         if (rep < lim) begin
            rep = rep + 1'b1;
            found = 1'b1;
            irq = acc;
         end
      end

      push = accept && (found || ending);
      push_rec.found = found;
      push_rec.done = ending;
      push_rec.irq = irq;
      push_rec.count = rep;

      phase_in = phase_ff;
      header_in = header_ff;
      acc_in = acc_ff;
      nz_in = nz_ff;
      rep_in = rep_ff;
      bytes_in = bytes_ff;
      fin_in = fin_ff;
      if (accept) begin
         if (ending) begin
            phase_in = italp_pkg::PH_LEAD;
            header_in = 1'b0;
            acc_in = '0;
            nz_in = 1'b0;
            rep_in = '0;
            bytes_in = '0;
            fin_in = 1'b0;
         end else begin
            phase_in = ph;
            header_in = hdr;
            acc_in = acc;
            nz_in = nz;
            rep_in = rep;
            bytes_in = bts;
            fin_in = fin;
         end
      end

      max_count_in = csr_wen ? csr_wdata : max_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= italp_pkg::PH_LEAD;
         header_ff <= 1'b0;
         acc_ff <= '0;
         nz_ff <= 1'b0;
         rep_ff <= '0;
         bytes_ff <= '0;
         fin_ff <= 1'b0;
         max_count_ff <= italp_pkg::MAX_COUNT_RESET;
      end else begin
         phase_ff <= phase_in;
         header_ff <= header_in;
         acc_ff <= acc_in;
         nz_ff <= nz_in;
         rep_ff <= rep_in;
         bytes_ff <= bytes_in;
         fin_ff <= fin_in;
         max_count_ff <= max_count_in;
      end
   end

endmodule

/* src/italp_queue.sv */
// Short record queue between the parser and the result serializer.
module italp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  italp_pkg::record_type push_rec,
   input  logic                  pop,
   output italp_pkg::record_type head_rec,
   output italp_pkg::qstat_type  status
);

   italp_pkg::record_type              mem_ff [italp_pkg::QUEUE_DEPTH];
   logic [italp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [italp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [italp_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;

   function automatic logic [italp_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
      return {{(italp_pkg::QCNT_W-1){1'b0}}, b};
   endfunction

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff + QCNT_ONE(push) - QCNT_ONE(pop);
      status.full = (cnt_ff == italp_pkg::QCNT_W'(italp_pkg::QUEUE_DEPTH));
      status.empty = (cnt_ff == '0);
      head_rec = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* src/italp_back.sv */
// Result serializer that turns queued records into output beats.
module italp_back (
   input  logic                               clock,
   input  logic                               reset,
   input  italp_pkg::record_type              head_rec,
   input  italp_pkg::qstat_type               status,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [italp_pkg::DATA_W-1:0]       rsp_tdata,
   output logic [italp_pkg::USER_W-1:0]       rsp_tuser,
   output logic                               rsp_tlast
);

   logic                               valid_ff, valid_in;
   logic                               sent_found_ff, sent_found_in;
   logic [italp_pkg::DATA_W-1:0]       data_ff, data_in;
   logic [italp_pkg::USER_W-1:0]       user_ff, user_in;
   logic                               last_ff, last_in;
   logic                               load;
   logic                               beat_found;
   logic                               last_beat;

   always_comb begin
      beat_found = head_rec.found && !sent_found_ff;
      last_beat = !beat_found || !head_rec.done;
      load = !status.empty && (!valid_ff || rsp_tready);
      pop = load && last_beat;

      valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      sent_found_in = load ? (beat_found && !last_beat) : sent_found_ff;

      data_in = data_ff;
      user_in = user_ff;
      last_in = last_ff;
      if (load) begin
         data_in = {(italp_pkg::DATA_W - italp_pkg::COUNT_W - italp_pkg::IRQ_W)'(0),
                    head_rec.count,
                    beat_found ? head_rec.irq : italp_pkg::IRQ_W'(0)};
         user_in = {!beat_found, beat_found};
         last_in = last_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_found_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_found_ff <= sent_found_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;
   assign rsp_tlast = last_ff;

endmodule

/* src/interrupt_table_active_line_parser.sv */
// Top level of the active interrupt line parser.
// The block scans an interrupt-count text table that arrives one byte per beat on the
// req_ channel and reports every line whose counters are not all zero on the rsp_ channel.
// Each result beat is either a found beat with the line's interrupt number or a done beat
// that closes the scan; both carry the number of lines reported so far. The last beat
// caused by one input byte has rsp_tlast set, and a byte causes at most two beats.
// The csr_ port writes the report limit, which resets to 512; the user must write it only while
// no scan result is pending, and the block itself does not enforce this.
// Throughput is one input byte per cycle while the queue is not full. The parser updates its
// line state and pushes a record into a four-entry queue; the serializer drains one beat per
// cycle while the receiver is ready, and the queue absorbs a byte that yields two beats.
// An accepted byte's record is written into the queue, then loaded into the output register.
// When the receiver stalls, the output register holds its beat, the queue fills, and
// req_tready drops only once the queue is full. Reset clears the parser state, the
// queue and the output valid flag, and returns the limit to 512.
module interrupt_table_active_line_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [italp_pkg::COUNT_W-1:0]     csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] text_byte
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [italp_pkg::DATA_W-1:0]      rsp_tdata,   // [11:0] irq_number, [24:12] active_count
   output logic [italp_pkg::USER_W-1:0]      rsp_tuser,   // [0] found, [1] scan_done
   output logic                              rsp_tlast
);

   logic                  accept;
   logic                  push;
   logic                  pop;
   italp_pkg::record_type push_rec;
   italp_pkg::record_type head_rec;
   italp_pkg::qstat_type  status;

   assign req_tready = !status.full;
   assign accept = req_tvalid && req_tready;

   italp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .text_byte  (req_tdata),
      .final_byte (req_tlast),
      .push       (push),
      .push_rec   (push_rec)
   );

   italp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .status   (status)
   );

   italp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/italp_checker.sv */
// Port-level checker for the active interrupt line parser, bound to the top level.
module italp_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [italp_pkg::DATA_W-1:0]      rsp_tdata,
   input  logic [italp_pkg::USER_W-1:0]      rsp_tuser,
   input  logic                              rsp_tlast
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result beat changed while stalled.");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tuser))
      else $error("Result beat is not exactly one of found and done.");

   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && (rsp_tdata[11:0] == 12'd0))
      else $error("Done beat without last flag or with a nonzero number.");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[24:12] != 13'd0))
      else $error("Found beat carries a zero count.");

endmodule

bind interrupt_table_active_line_parser italp_checker u_italp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* bench/tb_interrupt_table_active_line_parser.sv */
// Self-checking bench for the active interrupt line parser: table text in, reported lines out.
module tb_interrupt_table_active_line_parser;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] text;
      logic       fin;
   } text_beat_type;

   typedef struct packed {
      logic [italp_pkg::IRQ_W-1:0]   irq;
      logic                          found;
      logic                          done;
      logic [italp_pkg::COUNT_W-1:0] lines;
      logic                          last;
   } report_beat_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wen = 1'b0;
   logic [italp_pkg::COUNT_W-1:0]  csr_wdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [italp_pkg::DATA_W-1:0]   rsp_tdata;
   logic [italp_pkg::USER_W-1:0]   rsp_tuser;
   logic                           rsp_tlast;

   text_beat_type   text_q[$];
   report_beat_type expected_beats[$];
   logic [7:0]      table_text[$];
   text_beat_type   next_beat;
   report_beat_type seen_beat;
   report_beat_type want_beat;
   int              queued_items = 0;
   int              errors = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   logic            send_hold = 1'b0;
   logic            hold_kick = 1'b0;
   int              hold_left = 0;

   // Predicted parser state and the limit register as last written.
   italp_pkg::phase_type          ph = italp_pkg::PH_LEAD;
   logic                          hdr = 1'b0;
   logic                          nz = 1'b0;
   logic                          stopped = 1'b0;
   logic [italp_pkg::IRQ_W-1:0]   acc = '0;
   logic [italp_pkg::COUNT_W-1:0] nrep = '0;
   logic [italp_pkg::BYTES_W-1:0] ntaken = '0;
   logic [italp_pkg::COUNT_W-1:0] limit_reg = italp_pkg::MAX_COUNT_RESET;

   interrupt_table_active_line_parser uut (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void add_expect(logic [italp_pkg::IRQ_W-1:0] irq, logic found,
                                      logic done);
      report_beat_type e;
      e.irq = irq;
      e.found = found;
      e.done = done;
      e.lines = nrep;
      e.last = 1'b0;
      expected_beats.push_back(e);
   endfunction

   function automatic void restart_scan();
      ph = italp_pkg::PH_LEAD;
      hdr = 1'b0;
      acc = '0;
      nz = 1'b0;
      nrep = '0;
      ntaken = '0;
      stopped = 1'b0;
   endfunction

   function automatic int finish_line();
      int lim;
      int k;
      k = 0;
      if (nz) begin
         lim = (limit_reg > italp_pkg::COUNT_CAP) ? int'(italp_pkg::COUNT_CAP)
                                                  : int'(limit_reg);
         if (int'(nrep) < lim) begin
            nrep++;
            add_expect(acc, 1'b1, 1'b0);
            k = 1;
         end else begin
            stopped = 1'b1;
         end
      end
      ph = italp_pkg::PH_LEAD;
      nz = 1'b0;
      acc = '0;
      return k;
   endfunction

   function automatic int parse_char(logic [7:0] c);
      logic ws;
      logic dig;
      int   d;
      int   v;
      ws = (c == italp_pkg::CH_SPACE) || (c == italp_pkg::CH_TAB);
      dig = (c >= italp_pkg::CH_DIGIT_0) && (c <= italp_pkg::CH_DIGIT_9);
      d = dig ? int'(c - italp_pkg::CH_DIGIT_0) : 0;
      if (c == italp_pkg::CH_NEWLINE) return finish_line();
      case (ph)
         italp_pkg::PH_LEAD: begin
            if (!hdr) begin
               hdr = 1'b1;
               ph = italp_pkg::PH_SKIP;
            end else if (ws) begin
               ph = italp_pkg::PH_LEAD;
            end else if (dig) begin
               acc = italp_pkg::IRQ_W'(d);
               ph = italp_pkg::PH_NUM;
            end else begin
               ph = italp_pkg::PH_SKIP;
            end
         end
         italp_pkg::PH_NUM: begin
            if (dig) begin
               v = int'(acc) * 10 + d;
               if (v > int'(italp_pkg::MAX_IRQ)) ph = italp_pkg::PH_SKIP;
               else acc = italp_pkg::IRQ_W'(v);
            end else if (c == italp_pkg::CH_COLON) begin
               nz = 1'b0;
               ph = italp_pkg::PH_GAP;
            end else begin
               ph = italp_pkg::PH_SKIP;
            end
         end
         italp_pkg::PH_GAP, italp_pkg::PH_CNT: begin
            if (dig) begin
               if (d != 0) nz = 1'b1;
               ph = italp_pkg::PH_CNT;
            end else if (ws) begin
               ph = italp_pkg::PH_GAP;
            end else begin
               ph = italp_pkg::PH_SKIP;
            end
         end
         default: ph = italp_pkg::PH_SKIP;
      endcase
      return 0;
   endfunction

   function automatic void predict_beat(logic [7:0] c, logic fin);
      int              k;
      report_beat_type tail;
      k = 0;
      if (c != 8'h00 && !stopped && ntaken < italp_pkg::BYTE_LIMIT) begin
         ntaken++;
         k = parse_char(c);
      end
      if (c == 8'h00 || fin) begin
         if (!stopped) k += finish_line();
         add_expect('0, 1'b0, 1'b1);
         k++;
         restart_scan();
      end
      if (k > 0) begin
         tail = expected_beats.pop_back();
         tail.last = 1'b1;
         expected_beats.push_back(tail);
      end
   endfunction

   function automatic string beat_text(report_beat_type b);
      return $sformatf("irq=%0d found=%0b done=%0b lines=%0d last=%0b",
                       b.irq, b.found, b.done, b.lines, b.last);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_beat(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (text_q.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
               next_beat = text_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_beat.text;
               req_tlast <= next_beat.fin;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_kick) hold_left <= 80;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_beat.irq = rsp_tdata[italp_pkg::IRQ_W-1:0];
            seen_beat.lines = rsp_tdata[italp_pkg::IRQ_W+italp_pkg::COUNT_W-1:italp_pkg::IRQ_W];
            seen_beat.found = rsp_tuser[0];
            seen_beat.done = rsp_tuser[1];
            seen_beat.last = rsp_tlast;
            if (expected_beats.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, expected none, actual %s",
                        $time, beat_text(seen_beat));
            end else begin
               want_beat = expected_beats.pop_front();
               if (want_beat !== seen_beat) begin
                  errors++;
                  $display("%0t: mismatch, expected %s, actual %s",
                           $time, beat_text(want_beat), beat_text(seen_beat));
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic put_byte(logic [7:0] b, logic fin);
      text_beat_type t;
      t.text = b;
      t.fin = fin;
      text_q.push_back(t);
      queued_items++;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) table_text.push_back(s[i]);
   endtask

   task automatic add_decimal(int unsigned v);
      logic [7:0] digits[$];
      do begin
         digits.push_front(italp_pkg::CH_DIGIT_0 + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) table_text.push_back(digits[i]);
   endtask

   task automatic add_space();
      table_text.push_back($urandom_range(1) ? italp_pkg::CH_SPACE : italp_pkg::CH_TAB);
   endtask

   task automatic flush_table(bit fin_last, bit zero_end);
      foreach (table_text[i]) put_byte(table_text[i], fin_last && i == table_text.size() - 1);
      if (zero_end) put_byte(8'h00, 1'($urandom_range(1)));
      table_text.delete();
   endtask

   task automatic make_line();
      int r;
      int n;
      r = $urandom_range(99);
      repeat ($urandom_range(2)) add_space();
      if (r < 5) begin
         repeat ($urandom_range(1, 8)) table_text.push_back(8'($urandom_range(1, 255)));
      end else begin
         if (r < 12) begin
            add_decimal($urandom_range(4096, 70000));
         end else if (r < 20) begin
            table_text.push_back(italp_pkg::CH_DIGIT_0);
            add_decimal($urandom_range(0, 409));
         end else if (r < 25) begin
            add_decimal($urandom_range(1) ? 0 : italp_pkg::MAX_IRQ);
         end else begin
            add_decimal($urandom_range(0, italp_pkg::MAX_IRQ));
         end
         if (r >= 25 && r < 30) table_text.push_back(8'($urandom_range(59, 126)));
         table_text.push_back(italp_pkg::CH_COLON);
         n = $urandom_range(4);
         for (int i = 0; i < n; i++) begin
            repeat ($urandom_range(i == 0 ? 0 : 1, 3)) add_space();
            if ($urandom_range(99) < 65) begin
               repeat ($urandom_range(1, 2)) table_text.push_back(italp_pkg::CH_DIGIT_0);
            end else begin
               add_decimal($urandom_range(1, 99999));
            end
         end
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 4)) table_text.push_back(8'($urandom_range(33, 126)));
         end
      end
      table_text.push_back(italp_pkg::CH_NEWLINE);
   endtask

   task automatic make_table();
      int r;
      r = $urandom_range(99);
      if (r < 8) begin
         repeat ($urandom_range(1, 20)) table_text.push_back(8'($urandom_range(255)));
         flush_table(1'($urandom_range(1)), 1'b0);
         return;
      end
      if ($urandom_range(4) == 0) table_text.push_back(italp_pkg::CH_NEWLINE);
      repeat ($urandom_range(1, 6)) table_text.push_back(8'($urandom_range(32, 126)));
      table_text.push_back(italp_pkg::CH_NEWLINE);
      repeat ($urandom_range(1, 8)) make_line();
      if (r < 25) void'(table_text.pop_back());
      if (r < 70) flush_table(1'b1, 1'b0);
      else if (r < 90) flush_table(1'b0, 1'b1);
      else flush_table(1'b0, 1'b0);
   endtask

   task automatic drain_results();
      do @(posedge clock);
      while (text_q.size() != 0 || req_tvalid || expected_beats.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [italp_pkg::COUNT_W-1:0] v);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      limit_reg = v;
   endtask

   initial begin
      int start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_text("\nH\n\t4095:1\n4096:1\n12x:3\n");
      flush_table(1'b0, 1'b1);
      add_text("h\n7:2");
      flush_table(1'b1, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h80, 1'b1);
      drain_results();

      write_limit(italp_pkg::COUNT_W'(1));
      add_text("h\n1:1\n2:1\n3:1\n");
      flush_table(1'b1, 1'b0);
      drain_results();
      write_limit(italp_pkg::COUNT_W'(0));
      add_text("h\n1:0\n2:5\n3:4\n");
      flush_table(1'b1, 1'b0);
      drain_results();
      write_limit(italp_pkg::COUNT_W'(8191));
      add_text("h\n42:0 0\t7 z\n");
      flush_table(1'b0, 1'b1);
      drain_results();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_limit(italp_pkg::COUNT_W'($urandom_range(1, 10)));
            1: write_limit(italp_pkg::COUNT_W'(2));
            2: write_limit(italp_pkg::COUNT_W'($urandom_range(1, 10)));
            3: write_limit(italp_pkg::COUNT_W'($urandom_range(40, 4096)));
            4: write_limit(italp_pkg::COUNT_W'(8191));
            default: write_limit(italp_pkg::COUNT_W'($urandom_range(0, 8191)));
         endcase
         send_idle_pct = (phase < 2) ? 27 : (phase < 4) ? 62 : 0;
         recv_idle_pct = (phase < 2) ? 62 : (phase < 4) ? 27 : 0;
         start = queued_items;
         while (queued_items - start < 220) make_table();
         drain_results();

         if (phase == 3) begin
            // Dense active lines while the receiver holds off, then a full pause.
            send_idle_pct = 0;
            recv_idle_pct = 0;
            add_text("irq\n");
            for (int i = 0; i < 40; i++) begin
               add_decimal(i);
               add_text(":1\n");
            end
            flush_table(1'b1, 1'b0);
            hold_kick <= 1'b1;
            @(posedge clock);
            hold_kick <= 1'b0;
            while (text_q.size() != 0) @(posedge clock);
            send_hold <= 1'b1;
            add_text("irq\n");
            for (int i = 0; i < 20; i++) begin
               add_decimal(italp_pkg::MAX_IRQ - i);
               add_text(": 0 3\n");
            end
            flush_table(1'b0, 1'b1);
            do @(posedge clock);
            while (req_tvalid || expected_beats.size() != 0);
            send_hold <= 1'b0;
            drain_results();
         end
      end

      repeat (20) @(posedge clock);

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
